@@ rtl/core/open_addressing_hash_map_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hash map core
// Concurrent checks on clk, masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define OAHM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OAHM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/oahm_pkg.sv @@
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared types and codes of the open-addressed hash map.
// ----------------------------------------------------------------------------
`default_nettype none

package oahm_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 64;
	localparam int CNT_W   = 9;
	localparam int TAG_W   = 2;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 88;

	localparam logic [CNT_W-1:0] MAX_LIVE_RST = 9'd166;

	// slot tags
	localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
	localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
	localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// classification of one probed slot
	typedef struct packed {
		logic is_empty;
		logic is_hit;
		logic is_tomb;
		logic is_last;
	} probe_res_t;

endpackage

`default_nettype wire

@@ rtl/core/oahm_ram.sv @@
// ----------------------------------------------------------------------------
// oahm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/oahm_probe.sv @@
// ----------------------------------------------------------------------------
// oahm_probe
// Probe unit: classifies one slot read and steps the probe index.
// ----------------------------------------------------------------------------
`default_nettype none

module oahm_probe
	import oahm_pkg::*;
#(
	parameter int IDX_W = 8
) (
	input  wire slot_t              slot,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [IDX_W-1:0]   idx,
	input  wire logic [IDX_W-1:0]   cnt,
	output logic      [IDX_W-1:0]   next_idx,
	output probe_res_t              res
);

	always_comb begin
		res.is_empty = (slot.tag == TAG_EMPTY);
		res.is_hit   = (slot.tag == TAG_LIVE) && (slot.key == key);
		res.is_tomb  = (slot.tag != TAG_EMPTY) && (slot.tag != TAG_LIVE);
		res.is_last  = (cnt == {IDX_W{1'b1}});
		next_idx     = idx + {{(IDX_W-1){1'b0}}, 1'b1};   // wraps at the IDX_W width
	end

endmodule

`default_nettype wire

@@ rtl/core/open_addressing_hash_map.sv @@
// Flow: the item is taken in S_IDLE, each probed slot is checked in S_CHECK, and the result is
//   staged in S_RESP; m_tvalid rises once the output register is free (1..CAPACITY slots probed).
// s_tready is high only in S_IDLE, so no new item is taken while one is probed or held in S_RESP.
// Reset: counters clear, max_live returns to 166, then a clearing pass marks every slot empty;
//   s_tready stays low during it, cfg writes are taken.
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Linear-probing key/value map with tombstones, one slot probe per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_map
	import oahm_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// s_tdata: key_id[31:0], key_hash[63:32], write_value[127:64]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  wire logic [REQ_W-1:0]       s_tuser,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// m_tdata: status[1:0], read_value[65:2], is_new[66], live_count[75:67],
	//          tombstone_count[84:76], zero fill[87:85]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic                   cfg_we,
	input  wire logic [CNT_W-1:0]       cfg_wdata
);

	localparam int IDX_W = $clog2(CAPACITY);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic [CNT_W-1:0]  live_q, tomb_q, max_live_q;
	logic              m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [REQ_W-1:0]  req_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  wval_q;
	logic [IDX_W-1:0]  idx_q, cnt_q, tomb_idx_q;
	logic              tomb_seen_q;
	logic [STAT_W-1:0] res_status_q;
	logic [VAL_W-1:0]  res_rval_q;
	logic              res_new_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr, next_idx;
	slot_t             ram_wdata, cur;
	logic [SLOT_W-1:0] ram_rdata;
	probe_res_t        pr;

	logic              accept, finish, load_out;
	logic              tomb_any, no_room;
	logic [STAT_W-1:0] fin_status;
	logic [VAL_W-1:0]  fin_rval;
	logic              fin_new;
	logic [CNT_W-1:0]  live_d, tomb_d;

	assign cur = slot_t'(ram_rdata);

	oahm_ram #(
		.DATA_W(SLOT_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	oahm_probe #(
		.IDX_W(IDX_W)
	) u_probe (
		.slot    (cur),
		.key     (key_q),
		.idx     (idx_q),
		.cnt     (cnt_q),
		.next_idx(next_idx),
		.res     (pr)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == S_RESP) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// next read: start slot while idle, otherwise the following slot
	assign ram_raddr = (state_q == S_IDLE) ? s_tdata[KEY_W +: IDX_W] : next_idx;

	assign tomb_any = tomb_seen_q || pr.is_tomb;
	// limit check in one extra bit so max_live of 511 still admits
	assign no_room  = ({1'b0, live_q} + {{CNT_W{1'b0}}, 1'b1}) > {1'b0, max_live_q};

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = '0;
		finish     = 1'b0;
		fin_status = STAT_ABSENT;
		fin_rval   = '0;
		fin_new    = 1'b0;
		live_d     = live_q;
		tomb_d     = tomb_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
		end else if (state_q == S_CHECK) begin
			case (req_q)
				REQ_GET: begin
					if (pr.is_hit) begin
						finish     = 1'b1;
						fin_status = STAT_DONE;
						fin_rval   = cur.value;
					end else if (pr.is_empty || pr.is_last) begin
						finish = 1'b1;
					end
				end
				REQ_SET: begin
					if (pr.is_hit) begin
						finish     = 1'b1;
						fin_status = STAT_DONE;
						ram_we     = 1'b1;
						ram_wdata  = '{tag: TAG_LIVE, key: key_q, value: wval_q};
					end else if (pr.is_empty || pr.is_last) begin
						finish = 1'b1;
						if (no_room || (!tomb_any && !pr.is_empty)) begin
							fin_status = STAT_FULL;
						end else begin
							fin_status = STAT_DONE;
							fin_new    = 1'b1;
							ram_we     = 1'b1;
							ram_waddr  = tomb_seen_q ? tomb_idx_q : idx_q;
							ram_wdata  = '{tag: TAG_LIVE, key: key_q, value: wval_q};
							live_d     = live_q + {{(CNT_W-1){1'b0}}, 1'b1};
							if (tomb_any) begin
								tomb_d = tomb_q - {{(CNT_W-1){1'b0}}, 1'b1};
							end
						end
					end
				end
				REQ_DEL: begin
					if (pr.is_hit) begin
						finish     = 1'b1;
						fin_status = STAT_DONE;
						ram_we     = 1'b1;
						ram_wdata  = '{tag: TAG_TOMB, key: cur.key, value: cur.value};
						live_d     = live_q - {{(CNT_W-1){1'b0}}, 1'b1};
						tomb_d     = tomb_q + {{(CNT_W-1){1'b0}}, 1'b1};
					end else if (pr.is_empty || pr.is_last) begin
						finish = 1'b1;
					end
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			live_q     <= '0;
			tomb_q     <= '0;
			max_live_q <= MAX_LIVE_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_live_q <= cfg_wdata;
			end
			live_q <= live_d;
			tomb_q <= tomb_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + {{(IDX_W-1){1'b0}}, 1'b1};
					if (clr_idx_q == {IDX_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (finish) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= s_tuser;
			key_q       <= s_tdata[KEY_W-1:0];
			wval_q      <= s_tdata[IN_TDATA_W-1 -: VAL_W];
			idx_q       <= s_tdata[KEY_W +: IDX_W];
			cnt_q       <= '0;
			tomb_seen_q <= 1'b0;
		end else if (state_q == S_CHECK) begin
			idx_q <= next_idx;
			cnt_q <= cnt_q + {{(IDX_W-1){1'b0}}, 1'b1};
			if (pr.is_tomb && !tomb_seen_q) begin
				tomb_seen_q <= 1'b1;
				tomb_idx_q  <= idx_q;
			end
		end
		if (finish) begin
			res_status_q <= fin_status;
			res_rval_q   <= fin_rval;
			res_new_q    <= fin_new;
		end
		if (load_out) begin
			m_tdata_q <= {{(OUT_TDATA_W - STAT_W - VAL_W - 1 - 2*CNT_W){1'b0}},
				tomb_q, live_q, res_new_q, res_rval_q, res_status_q};
		end
	end

	`include "open_addressing_hash_map_assert.svh"

	`OAHM_ASSERT_IMP(a_we_phase, ram_we, (state_q == S_CLEAR) || (state_q == S_CHECK), "slot write outside clear or probe")
	`OAHM_ASSERT_NXT(a_accept_probe, accept, (state_q == S_CHECK) && (cnt_q == '0), "accepted item did not start probing")
	`OAHM_ASSERT_NXT(a_cnt_hold, !ram_we, $stable(live_q) && $stable(tomb_q), "counters moved without a slot write")
	`OAHM_ASSERT_IMP(a_new_done, m_tvalid_q && m_tdata_q[STAT_W+VAL_W], m_tdata_q[STAT_W-1:0] == STAT_DONE, "new key reported without done status")

endmodule

`default_nettype wire
